// File: src/ifr_pkg.sv
package ifr_pkg;

    // receiver phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_BODY  = 2'd2,
        PH_DRAIN = 2'd3
    } phase_t;

    // frame status codes
    localparam logic [1:0] ST_BUSY     = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_BAD_LEN  = 2'd3;

    // configuration register indexes
    localparam logic REG_MAX_FRAME_LEN = 1'b0;

    localparam logic [6:0] MAX_FRAME_LEN_RESET = 7'd32;
    localparam logic [6:0] LEN_MASK            = 7'h7F;

    // one result item
    typedef struct packed {
        logic       previous_cut_short;
        logic [1:0] status;
        logic       frame_end;
        logic       discarded;
        logic       is_body;
        logic [6:0] byte_index;
        logic [7:0] plain_byte;
    } res_t;

endpackage

// File: src/inverted_frame_receiver_unit.sv
// a result is registered for m_ when its byte request is accepted, into the skid entry if m_ is stalled
// throughput: one byte per cycle while the skid entry is empty; framing is a single pass from the input port
// into a result register, with one skid entry so input continues while a result waits
// reset (aresetn low, synchronous): receiver waits for a first byte, counters and
// checksum cleared, max_frame_len back to 32, output and skid entries empty
module inverted_frame_receiver_unit
    import ifr_pkg::*;
#(
    parameter int HEADER_BYTES = 9
)
(
    input  logic        aclk,
    input  logic        aresetn,
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] bus_byte
    input  logic        s_tuser,   // [0] gap_before
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] plain_byte, [14:8] byte_index, [15] zero
    output logic [4:0]  m_tuser,   // [0] is_body, [1] discarded, [3:2] status,
                                   // [4] previous_cut_short
    output logic        m_tlast,   // frame_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0] max_frame_len;
    logic       accept;
    res_t       res;
    res_t       out_res;

    ifr_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .max_frame_len (max_frame_len)
    );

    assign accept = s_tvalid & s_tready;

    ifr_frame #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_frame (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .bus_byte      (s_tdata),
        .gap_before    (s_tuser),
        .max_frame_len (max_frame_len),
        .res           (res)
    );

    ifr_oskid u_oskid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // pack result fields onto the stream
    assign m_tdata = {1'b0, out_res.byte_index, out_res.plain_byte};
    assign m_tuser = {out_res.previous_cut_short, out_res.status,
                      out_res.discarded, out_res.is_body};
    assign m_tlast = out_res.frame_end;

endmodule

// File: src/ifr_regs.sv
module ifr_regs
    import ifr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [6:0]  max_frame_len
);

    logic [6:0] max_len_reg;
    logic [6:0] max_len_next;
    logic       wr_en;

    // write strobe on the access phase
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_MAX_FRAME_LEN);

    always_comb begin
        max_len_next = max_len_reg;
        if (wr_en) begin
            max_len_next = pwdata[6:0] & LEN_MASK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_FRAME_LEN_RESET;
        end else begin
            max_len_reg <= max_len_next;
        end
    end

    // read back
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_MAX_FRAME_LEN) begin
            prdata = {25'd0, max_len_reg};
        end
    end

    assign max_frame_len = max_len_reg;

endmodule

// File: src/ifr_frame.sv
module ifr_frame
    import ifr_pkg::*;
#(
    parameter int HEADER_BYTES = 9
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] bus_byte,
    input  logic       gap_before,
    input  logic [6:0] max_frame_len,
    output res_t       res
);

    localparam logic [7:0] MIN_LEN = 8'(HEADER_BYTES + 2);

    phase_t      phase_reg,    phase_next;
    logic [6:0]  count_reg,    count_next;
    logic [6:0]  flen_reg,     flen_next;
    logic [15:0] sum_reg,      sum_next;
    logic [7:0]  csum_hi_reg,  csum_hi_next;

    phase_t      ph_eff;
    logic [7:0]  inv;
    logic [6:0]  len;
    logic [7:0]  count_p2;
    logic [15:0] rx_sum;

    assign inv      = ~bus_byte;
    assign len      = inv[6:0] & LEN_MASK;
    assign count_p2 = {1'b0, count_reg} + 8'd2;
    assign rx_sum   = {csum_hi_reg, bus_byte};

    // per-byte framing step
    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        flen_next    = flen_reg;
        sum_next     = sum_reg;
        csum_hi_next = csum_hi_reg;
        res          = '0;

        ph_eff = phase_reg;
        if (gap_before) begin
            res.previous_cut_short = (phase_reg == PH_LEN) || (phase_reg == PH_BODY);
            ph_eff = PH_IDLE;
        end

        unique case (ph_eff)
            PH_IDLE: begin
                res.plain_byte = inv;
                res.is_body    = 1'b1;
                sum_next       = {8'd0, bus_byte};
                csum_hi_next   = 8'd0;
                flen_next      = 7'd0;
                count_next     = 7'd1;
                phase_next     = PH_LEN;
            end
            PH_LEN: begin
                res.plain_byte = inv;
                res.byte_index = 7'd1;
                res.is_body    = 1'b1;
                sum_next       = sum_reg + {8'd0, bus_byte};
                flen_next      = len;
                if (({1'b0, len} < MIN_LEN) || (len > max_frame_len)) begin
                    res.frame_end = 1'b1;
                    res.status    = ST_BAD_LEN;
                    phase_next    = PH_DRAIN;
                end else begin
                    count_next = 7'd2;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                res.byte_index = count_reg;
                if (count_p2 < {1'b0, flen_reg}) begin
                    // header or data byte
                    res.plain_byte = inv;
                    res.is_body    = 1'b1;
                    sum_next       = sum_reg + {8'd0, bus_byte};
                    count_next     = count_reg + 7'd1;
                end else if (count_p2 == {1'b0, flen_reg}) begin
                    // checksum high byte
                    res.plain_byte = bus_byte;
                    csum_hi_next   = bus_byte;
                    count_next     = count_reg + 7'd1;
                end else begin
                    // checksum low byte closes the frame
                    res.plain_byte = bus_byte;
                    res.frame_end  = 1'b1;
                    res.status     = (rx_sum == sum_reg) ? ST_OK : ST_MISMATCH;
                    count_next     = 7'd0;
                    phase_next     = PH_IDLE;
                end
            end
            PH_DRAIN: begin
                res.discarded = 1'b1;
                phase_next    = PH_DRAIN;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // frame state, advanced once per accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            count_reg   <= 7'd0;
            flen_reg    <= 7'd0;
            sum_reg     <= 16'd0;
            csum_hi_reg <= 8'd0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            flen_reg    <= flen_next;
            sum_reg     <= sum_next;
            csum_hi_reg <= csum_hi_next;
        end
    end

endmodule

// File: src/ifr_oskid.sv
module ifr_oskid
    import ifr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic out_valid_reg,  out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_data_reg,   out_data_next;
    res_t skid_data_reg,  skid_data_next;
    logic in_fire;

    assign in_ready = ~skid_valid_reg;
    assign in_fire  = in_valid & in_ready;

    // result register with one skid entry behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !out_ready) begin
            if (in_fire) begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = in_fire;
            if (in_fire) begin
                out_data_next = in_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: test/inverted_frame_receiver_unit_test.sv
`timescale 1ns / 100ps

module inverted_frame_receiver_unit_test;
    import ifr_pkg::*;

    localparam int HEADER_LEN = 9;
    localparam int MIN_FRAME  = HEADER_LEN + 2;
    localparam int ERR_PRINTS = 20;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] bus_byte
    logic        s_tuser;   // [0] gap_before
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] plain_byte, [14:8] byte_index, [15] zero
    logic [4:0]  m_tuser;   // [0] is_body, [1] discarded, [3:2] status,
                            // [4] previous_cut_short
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    inverted_frame_receiver_unit #(.HEADER_BYTES(HEADER_LEN)) dut (.*);

    // receiver model state
    phase_t      rx_phase     = PH_IDLE;
    logic [6:0]  rx_count     = '0;
    logic [6:0]  rx_frame_len = '0;
    logic [15:0] rx_sum       = '0;
    logic [7:0]  rx_ck_high   = '0;
    logic [6:0]  max_len_q    = MAX_FRAME_LEN_RESET;

    // framed bytes still to come out of the block
    res_t framed_bytes[$];

    int n_errors    = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int n_ok        = 0;
    int n_bad_sum   = 0;
    int n_bad_len   = 0;
    int n_cut_short = 0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // overall limit
    initial begin
        #2_000_000;
        $display("** inverted_frame_receiver_unit: FAILED **");
        $finish;
    end

    // frame one bus byte and advance the receiver model
    function automatic res_t frame_byte(input logic [7:0] b, input logic gap);
        res_t r;
        logic [7:0] inv;
        logic [6:0] len;
        logic [15:0] rx;
        r = '0;
        inv = ~b;
        if (gap) begin
            if (rx_phase == PH_LEN || rx_phase == PH_BODY)
                r.previous_cut_short = 1'b1;
            rx_phase = PH_IDLE;
        end
        case (rx_phase)
            PH_IDLE: begin
                r.plain_byte = inv;
                r.is_body = 1'b1;
                rx_sum = {8'h00, b};
                rx_ck_high = '0;
                rx_frame_len = '0;
                rx_count = 7'd1;
                rx_phase = PH_LEN;
            end
            PH_LEN: begin
                len = inv[6:0] & LEN_MASK;
                r.plain_byte = inv;
                r.byte_index = 7'd1;
                r.is_body = 1'b1;
                rx_sum = rx_sum + {8'h00, b};
                rx_frame_len = len;
                if (int'(len) < MIN_FRAME || len > max_len_q) begin
                    r.frame_end = 1'b1;
                    r.status = ST_BAD_LEN;
                    rx_phase = PH_DRAIN;
                end else begin
                    rx_count = 7'd2;
                    rx_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                r.byte_index = rx_count;
                if (int'(rx_count) + 2 < int'(rx_frame_len)) begin
                    r.plain_byte = inv;
                    r.is_body = 1'b1;
                    rx_sum = rx_sum + {8'h00, b};
                    rx_count = rx_count + 7'd1;
                end else if (int'(rx_count) + 2 == int'(rx_frame_len)) begin
                    r.plain_byte = b;
                    rx_ck_high = b;
                    rx_count = rx_count + 7'd1;
                end else begin
                    rx = {rx_ck_high, b};
                    r.plain_byte = b;
                    r.frame_end = 1'b1;
                    r.status = (rx == rx_sum) ? ST_OK : ST_MISMATCH;
                    rx_count = '0;
                    rx_phase = PH_IDLE;
                end
            end
            default: begin
                r.discarded = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (n_errors < ERR_PRINTS)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
        n_errors++;
    endtask

    // send one byte request, idling between bursts
    task automatic push_byte(input logic [7:0] b, input logic gap);
        res_t r;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= gap;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = frame_byte(b, gap);
        framed_bytes.push_back(r);
        if (r.frame_end) begin
            case (r.status)
                ST_OK:       n_ok++;
                ST_MISMATCH: n_bad_sum++;
                ST_BAD_LEN:  n_bad_len++;
                default:     ;
            endcase
        end
        if (r.previous_cut_short) n_cut_short++;
        items_sent++;
        burst_left--;
    endtask

    // stop sending and let every framed byte come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (framed_bytes.size() != 0) @(posedge aclk);
    endtask

    // register write over the config port, block idle
    task automatic set_max_len(input logic [6:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_MAX_FRAME_LEN) << 2;
        pwdata  <= {25'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        max_len_q = value;
    endtask

    // build a frame on the bus: inverted header and data, plain checksum
    task automatic send_frame(input int len, input bit bad_sum, input bit lead_gap,
                              input int stop_after);
        logic [7:0] fb [0:127];
        logic [15:0] sum;
        int n;
        fb[0] = 8'($urandom_range(0, 255));
        fb[1] = ~{1'($urandom_range(0, 1)), 7'(len)};
        if (len >= MIN_FRAME && len <= int'(max_len_q)) begin
            n = len;
            sum = {8'h00, fb[0]} + {8'h00, fb[1]};
            for (int i = 2; i < len - 2; i++) begin
                fb[i] = 8'($urandom_range(0, 255));
                sum = sum + {8'h00, fb[i]};
            end
            fb[len - 2] = sum[15:8];
            fb[len - 1] = sum[7:0];
            if (bad_sum)
                fb[len - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        end else begin
            // bad length, a few bytes to be dropped
            n = 2 + $urandom_range(0, 5);
            for (int i = 2; i < n; i++) fb[i] = 8'($urandom_range(0, 255));
        end
        if (stop_after > 0 && stop_after < n) n = stop_after;
        for (int i = 0; i < n; i++) push_byte(fb[i], (i == 0) ? lead_gap : 1'b0);
    endtask

    task automatic send_noise(input int count);
        repeat (count) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    // edge cases at the reset maximum
    task automatic test_directed();
        // first byte without a gap while waiting, shortest legal frame
        send_frame(MIN_FRAME, 1'b0, 1'b0, 0);
        // length 127 over the maximum, then a dropped byte
        push_byte(8'h00, 1'b1);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        // gap while dropping starts a frame without a cut-short flag
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        // gap right after the id byte cuts the frame short
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(~8'd10, 1'b0);
        // good length, then cut short inside the body
        push_byte(8'h5A, 1'b1);
        push_byte(~8'd32, 1'b0);
        push_byte(8'hA5, 1'b0);
    endtask

    // mostly well-formed frames, plus cuts, bad lengths and noise
    task automatic test_random_traffic(input int n_items);
        int start;
        int kind;
        int len;
        int top;
        int bad;
        start = items_sent;
        while (items_sent - start < n_items) begin
            kind = $urandom_range(0, 99);
            if (max_len_q >= MIN_FRAME) begin
                top = (max_len_q > 20) ? 20 : int'(max_len_q);
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(MIN_FRAME, max_len_q)
                                                  : $urandom_range(MIN_FRAME, top);
            end else begin
                len = $urandom_range(MIN_FRAME, 20);
            end
            if (max_len_q < 127 && $urandom_range(0, 1) == 1)
                bad = $urandom_range(int'(max_len_q) + 1, 127);
            else
                bad = $urandom_range(0, MIN_FRAME - 1);
            if (kind < 65)
                send_frame(len, $urandom_range(0, 3) == 0, 1'b1, 0);
            else if (kind < 75)
                send_frame(len, 1'b0, 1'b1, $urandom_range(1, len - 1));
            else if (kind < 83)
                send_frame(bad, 1'b0, 1'b1, 0);
            else if (kind < 92)
                send_noise($urandom_range(1, 6));
            else
                send_frame(len, 1'b0, 1'b0, 0);
        end
    endtask

    // maximum below the shortest legal frame, every length bad
    task automatic test_below_minimum();
        set_max_len(7'(MIN_FRAME - 1));
        send_frame(MIN_FRAME, 1'b0, 1'b1, 0);
        test_random_traffic(100);
    endtask

    task automatic test_length_extremes();
        set_max_len(7'(MIN_FRAME));
        test_random_traffic(250);
        set_max_len(7'd127);
        test_random_traffic(350);
    endtask

    task automatic test_random_maximum();
        repeat (3) begin
            set_max_len(7'($urandom_range(MIN_FRAME + 1, 126)));
            test_random_traffic(200);
        end
    endtask

    // result receiver stall pattern
    initial begin
        int hold;
        int ready_mode;
        hold = 0;
        ready_mode = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold == 0) begin
                ready_mode = $urandom_range(0, 2);
                case (ready_mode)
                    0:       hold = $urandom_range(20, 80);
                    1:       hold = $urandom_range(10, 40);
                    default: hold = $urandom_range(1, 12);
                endcase
            end
            hold--;
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= 1'b0;
            endcase
        end
    end

    // compare each result with the oldest framed byte
    always @(posedge aclk) begin : check_results
        res_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (framed_bytes.size() == 0) begin
                report_mismatch("result with none pending", int'(m_tdata), 0);
            end else begin
                want = framed_bytes.pop_front();
                if (m_tdata[7:0] !== want.plain_byte)
                    report_mismatch("plain_byte", m_tdata[7:0], want.plain_byte);
                if (m_tdata[14:8] !== want.byte_index)
                    report_mismatch("byte_index", m_tdata[14:8], want.byte_index);
                if (m_tuser[0] !== want.is_body)
                    report_mismatch("is_body", m_tuser[0], want.is_body);
                if (m_tuser[1] !== want.discarded)
                    report_mismatch("discarded", m_tuser[1], want.discarded);
                if (m_tlast !== want.frame_end)
                    report_mismatch("frame_end", m_tlast, want.frame_end);
                if (m_tuser[3:2] !== want.status)
                    report_mismatch("status", m_tuser[3:2], want.status);
                if (m_tuser[4] !== want.previous_cut_short)
                    report_mismatch("previous_cut_short", m_tuser[4],
                                    want.previous_cut_short);
            end
        end
    end

    // main sequence
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic(250);
        test_length_extremes();
        test_below_minimum();
        test_random_maximum();

        wait_drained();
        repeat (4) @(posedge aclk);
        $display("%0d bytes framed: %0d good frames, %0d checksum errors, %0d bad lengths,",
                 items_sent, n_ok, n_bad_sum, n_bad_len);
        $display("%0d cut-short frames, maximum length swept from 10 to 127", n_cut_short);
        if (n_errors == 0) begin
            $display("** inverted_frame_receiver_unit: PASSED **");
        end else begin
            $display("** inverted_frame_receiver_unit: FAILED **");
        end
        $finish;
    end

endmodule
